>>> hdl/dltq_pkg.sv
package dltq_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int ID_W       = 4;
  localparam int ID_COUNT   = 16;
  localparam int DELTA_W    = 32;
  localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W      = $clog2(NUM_TIMERS + 1);

  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_STOP  = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic [ID_W-1:0]    timer_id;
    logic [DELTA_W-1:0] period;
    logic               reload;
  } in_item_t;

  typedef struct packed {
    logic            ok;
    logic            expired_valid;
    logic [ID_W-1:0] expired_id;
    logic            last;
  } out_item_t;

endpackage

>>> hdl/dltq_out_reg.sv
module dltq_out_reg
  import dltq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  out_item_t load_data,
  output logic      load_rdy,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      valid_r;
  out_item_t data_r;

  // free when empty or when the held request leaves this cycle
  assign load_rdy  = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_rdy) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_rdy) begin
      data_r <= load_data;
    end
  end

endmodule

>>> hdl/delta_list_timer_queue.sv
// delta list timer queue
// in_data carries one request: start (timer id, period, reload), stop (timer id)
// or one elapsed tick. in_stall stays high while a request is being worked on,
// so one request is taken at a time.
// out_data gives ok, expired_valid, expired_id and last; a start, a stop or an
// unknown code gives one result, a tick gives one result per expired timer in
// expiry order (or one empty result), with last set on the final one.
// the list is walked one slot per cycle by a small sequencer around a single
// 32-bit add/subtract unit with a compare in front of it:
//   start: search, ordered walk, shift up
//   stop:  search, delta hand-over, shift down
//   tick:  head decrement, a pop and shift down per expired timer, a reinsertion
//          walk for each reloading timer, then the results
// results leave through a one-deep output register; while it is full and
// out_stall is high the sequencer waits in its emit state and takes no new request.
// reset (rst_n low, synchronous) empties the list and clears every reload flag;
// list slots and stored periods are only read once written.
module delta_list_timer_queue
  import dltq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_FIND = 10'b0000000010,
    S_INS  = 10'b0000000100,
    S_SHUP = 10'b0000001000,
    S_SADD = 10'b0000010000,
    S_SHDN = 10'b0000100000,
    S_TICK = 10'b0001000000,
    S_POP  = 10'b0010000000,
    S_RLD  = 10'b0100000000,
    S_EMIT = 10'b1000000000
  } state_t;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(NUM_TIMERS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  // list storage in slot order
  logic [ID_W-1:0]    ids_r   [NUM_TIMERS];
  logic [DELTA_W-1:0] delta_r [NUM_TIMERS];
  // per id settings
  logic [DELTA_W-1:0] period_r [ID_COUNT];
  logic [ID_COUNT-1:0] reload_r;
  // ids popped by the current tick
  logic [ID_W-1:0]    pop_r [NUM_TIMERS];

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   i_r, i_nxt;
  logic [CNT_W-1:0]   pos_r, pos_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [CNT_W-1:0]   k_r, k_nxt;
  logic [1:0]         func_r, func_nxt;
  logic [ID_W-1:0]    id_r, id_nxt;
  logic [DELTA_W-1:0] rem_r, rem_nxt;
  logic               rl_r, rl_nxt;
  logic               ok_r, ok_nxt;

  // read port and write port of the list
  logic [IDX_W-1:0]   rd_idx;
  logic [ID_W-1:0]    rd_id;
  logic [DELTA_W-1:0] rd_dl;
  logic               wr_en, wr_id_en;
  logic [IDX_W-1:0]   wr_idx;
  logic [ID_W-1:0]    wr_id;
  logic [DELTA_W-1:0] wr_dl;

  // per id write and pop write
  logic               set_en;
  logic               pop_en;

  // shared arithmetic unit
  logic [DELTA_W-1:0] au_a, au_b;
  logic               au_sub;
  logic [DELTA_W:0]   au_res;
  logic               rem_ge;

  logic [ID_W-1:0]    rl_id;
  logic               out_load, out_rdy;
  out_item_t          out_item;

  assign rd_id  = ids_r[rd_idx];
  assign rd_dl  = delta_r[rd_idx];
  assign rem_ge = (rem_r >= rd_dl);
  assign au_res = au_sub ? ({1'b0, au_a} - {1'b0, au_b}) : ({1'b0, au_a} + {1'b0, au_b});
  assign rl_id  = pop_r[k_r[IDX_W-1:0]];
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    i_nxt     = i_r;
    pos_nxt   = pos_r;
    n_nxt     = n_r;
    k_nxt     = k_r;
    func_nxt  = func_r;
    id_nxt    = id_r;
    rem_nxt   = rem_r;
    rl_nxt    = rl_r;
    ok_nxt    = ok_r;
    rd_idx    = i_r[IDX_W-1:0];
    wr_en     = 1'b0;
    wr_id_en  = 1'b0;
    wr_idx    = i_r[IDX_W-1:0];
    wr_id     = id_r;
    wr_dl     = rd_dl;
    set_en    = 1'b0;
    pop_en    = 1'b0;
    au_a      = rem_r;
    au_b      = rd_dl;
    au_sub    = 1'b1;
    out_load  = 1'b0;
    out_item  = '{ok: ok_r, expired_valid: 1'b0, expired_id: '0, last: 1'b1};

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt = in_data.func;
          id_nxt   = in_data.timer_id;
          rem_nxt  = in_data.period;
          rl_nxt   = in_data.reload;
          i_nxt    = '0;
          n_nxt    = '0;
          k_nxt    = '0;
          ok_nxt   = 1'b0;
          unique case (in_data.func)
            FUNC_START: state_nxt = (in_data.period == '0) ? S_EMIT : S_FIND;
            FUNC_STOP:  state_nxt = S_FIND;
            FUNC_TICK:  state_nxt = S_TICK;
            default:    state_nxt = S_EMIT;
          endcase
        end
      end
      S_FIND: begin
        if (i_r == cnt_r) begin
          if (func_r == FUNC_START && cnt_r < CNT_MAX) begin
            set_en    = 1'b1;
            i_nxt     = '0;
            state_nxt = S_INS;
          end else begin
            ok_nxt    = 1'b0;
            state_nxt = S_EMIT;
          end
        end else if (rd_id == id_r) begin
          if (func_r == FUNC_START) begin
            ok_nxt    = 1'b1;
            state_nxt = S_EMIT;
          end else begin
            rem_nxt   = rd_dl;
            pos_nxt   = i_r;
            state_nxt = S_SADD;
          end
        end else begin
          i_nxt = i_r + CNT_ONE;
        end
      end
      // ordered walk: spend deltas until the new timer fits
      S_INS: begin
        if (i_r == cnt_r) begin
          pos_nxt   = cnt_r;
          state_nxt = S_SHUP;
        end else if (rem_ge) begin
          rem_nxt = au_res[DELTA_W-1:0];
          i_nxt   = i_r + CNT_ONE;
        end else begin
          au_a      = rd_dl;
          au_b      = rem_r;
          wr_en     = 1'b1;
          wr_dl     = au_res[DELTA_W-1:0];
          pos_nxt   = i_r;
          i_nxt     = cnt_r;
          state_nxt = S_SHUP;
        end
      end
      // open a slot at pos by moving the tail up one entry a cycle
      S_SHUP: begin
        if (i_r == pos_r) begin
          wr_en    = 1'b1;
          wr_id_en = 1'b1;
          wr_idx   = pos_r[IDX_W-1:0];
          wr_id    = id_r;
          wr_dl    = rem_r;
          cnt_nxt  = cnt_r + CNT_ONE;
          if (func_r == FUNC_TICK) begin
            k_nxt     = k_r + CNT_ONE;
            state_nxt = S_RLD;
          end else begin
            ok_nxt    = 1'b1;
            state_nxt = S_EMIT;
          end
        end else begin
          rd_idx   = IDX_W'(i_r - CNT_ONE);
          wr_en    = 1'b1;
          wr_id_en = 1'b1;
          wr_id    = rd_id;
          wr_dl    = rd_dl;
          i_nxt    = i_r - CNT_ONE;
        end
      end
      // hand the removed delta on to the next entry, saturating
      S_SADD: begin
        rd_idx = IDX_W'(pos_r + CNT_ONE);
        au_a   = rd_dl;
        au_b   = rem_r;
        au_sub = 1'b0;
        if ((pos_r + CNT_ONE) < cnt_r) begin
          wr_en  = 1'b1;
          wr_idx = IDX_W'(pos_r + CNT_ONE);
          wr_dl  = au_res[DELTA_W] ? '1 : au_res[DELTA_W-1:0];
        end
        i_nxt     = pos_r;
        state_nxt = S_SHDN;
      end
      // close the gap at i by moving the tail down
      S_SHDN: begin
        if ((i_r + CNT_ONE) < cnt_r) begin
          rd_idx   = IDX_W'(i_r + CNT_ONE);
          wr_en    = 1'b1;
          wr_id_en = 1'b1;
          wr_id    = rd_id;
          wr_dl    = rd_dl;
          i_nxt    = i_r + CNT_ONE;
        end else begin
          cnt_nxt = cnt_r - CNT_ONE;
          if (func_r == FUNC_TICK) begin
            state_nxt = S_POP;
          end else begin
            ok_nxt    = 1'b1;
            state_nxt = S_EMIT;
          end
        end
      end
      S_TICK: begin
        rd_idx = '0;
        au_a   = rd_dl;
        au_b   = DELTA_W'(1);
        if (cnt_r != '0 && rd_dl != '0) begin
          wr_en  = 1'b1;
          wr_idx = '0;
          wr_dl  = au_res[DELTA_W-1:0];
        end
        state_nxt = S_POP;
      end
      S_POP: begin
        rd_idx = '0;
        if (cnt_r != '0 && rd_dl == '0) begin
          pop_en    = 1'b1;
          n_nxt     = n_r + CNT_ONE;
          i_nxt     = '0;
          state_nxt = S_SHDN;
        end else begin
          k_nxt     = '0;
          state_nxt = S_RLD;
        end
      end
      // reinsert reloading timers in pop order
      S_RLD: begin
        if (k_r == n_r) begin
          k_nxt     = '0;
          state_nxt = S_EMIT;
        end else if (reload_r[rl_id] && period_r[rl_id] != '0 && cnt_r < CNT_MAX) begin
          id_nxt    = rl_id;
          rem_nxt   = period_r[rl_id];
          i_nxt     = '0;
          state_nxt = S_INS;
        end else begin
          k_nxt = k_r + CNT_ONE;
        end
      end
      S_EMIT: begin
        if (out_rdy) begin
          out_load = 1'b1;
          if (func_r == FUNC_TICK && n_r != '0) begin
            out_item = '{ok: 1'b1, expired_valid: 1'b1, expired_id: rl_id,
                         last: (k_r + CNT_ONE) == n_r};
            k_nxt = k_r + CNT_ONE;
            if ((k_r + CNT_ONE) == n_r) begin
              state_nxt = S_IDLE;
            end
          end else begin
            if (func_r == FUNC_TICK) begin
              out_item.ok = 1'b1;
            end
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      reload_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (set_en) begin
        reload_r[id_r] <= rl_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r    <= i_nxt;
    pos_r  <= pos_nxt;
    n_r    <= n_nxt;
    k_r    <= k_nxt;
    func_r <= func_nxt;
    id_r   <= id_nxt;
    rem_r  <= rem_nxt;
    rl_r   <= rl_nxt;
    ok_r   <= ok_nxt;
    if (wr_en) begin
      delta_r[wr_idx] <= wr_dl;
    end
    if (wr_en && wr_id_en) begin
      ids_r[wr_idx] <= wr_id;
    end
    if (set_en) begin
      period_r[id_r] <= rem_r;
    end
    if (pop_en) begin
      pop_r[n_r[IDX_W-1:0]] <= rd_id;
    end
  end

  dltq_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (out_load),
    .load_data (out_item),
    .load_rdy  (out_rdy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX)
    else $error("timer count beyond list depth");

  a_pop_range: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CNT_MAX)
    else $error("pop count beyond list depth");

  a_load_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_rdy)
    else $error("result loaded while output register busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("request taken without work starting");
`endif

endmodule
